### sv/lcs_row_update_stream_assert.svh
// Assertion macros shared by the LCS row update stream RTL.
`ifndef LCS_ROW_UPDATE_STREAM_ASSERT_SVH
`define LCS_ROW_UPDATE_STREAM_ASSERT_SVH

// Same-cycle implication, sampled on clk, ignored while rst is high.
`define LCSRU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcs_row_update_stream: same-cycle check failed");

// Next-cycle implication, sampled on clk, ignored while rst is high.
`define LCSRU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcs_row_update_stream: next-cycle check failed");

`endif

### sv/lcsru_pkg.sv
// Shared types, constants and helpers for the LCS row update stream.
package lcsru_pkg;

  localparam int ROW_BITS        = 15;
  localparam int MAX_PATTERN_DEF = 15;
  localparam int SYM_W           = 2;
  localparam int LEN_W           = 4;
  localparam int PAT_W           = 2 * ROW_BITS;
  localparam int CFG_IDX_W       = 1;
  localparam int S_TDATA_W       = 8;
  localparam int M_TDATA_W       = 24;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(15);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN = 1'b0,
    CFG_LENGTH  = 1'b1
  } cfg_idx_t;

  // One text request as held in the input register.
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             first;
  } item_t;

  // Number of set bits in each nibble value.
  localparam logic [2:0] NIB_CNT [16] = '{
    3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
    3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
  };

  // Population count of a row mask as a two-level tree of nibble lookups.
  function automatic logic [LEN_W-1:0] popcount_row(input logic [ROW_BITS-1:0] m);
    logic [ROW_BITS:0] w;
    logic [LEN_W-1:0]  lo;
    logic [LEN_W-1:0]  hi;
    w  = {1'b0, m};
    lo = LEN_W'(NIB_CNT[w[3:0]])   + LEN_W'(NIB_CNT[w[7:4]]);
    hi = LEN_W'(NIB_CNT[w[11:8]])  + LEN_W'(NIB_CNT[w[15:12]]);
    return lo + hi;
  endfunction

endpackage

### sv/lcsru_core.sv
// Bit-parallel LCS row update: one text symbol against the configured pattern.
module lcsru_core #(
  parameter int ROW_W = 15
) (
  input  lcsru_pkg::item_t                 item,
  input  logic [ROW_W-1:0]                 dp_row,
  input  logic [lcsru_pkg::PAT_W-1:0]      pattern_symbols,
  input  logic [lcsru_pkg::LEN_W-1:0]      pattern_length,
  output logic [lcsru_pkg::ROW_BITS-1:0]   row_mask,
  output logic [lcsru_pkg::LEN_W-1:0]      lcs_length
);
  import lcsru_pkg::*;

  localparam logic [LEN_W-1:0] ROW_W_L = LEN_W'(ROW_W);

  logic [LEN_W-1:0] len_used;
  logic [ROW_W-1:0] len_mask;
  logic [ROW_W-1:0] match;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] v_old;
  logic [ROW_W-1:0] u;
  logic [ROW_W-1:0] v_new;
  logic [ROW_W-1:0] mask_new;

  assign len_used = (pattern_length > ROW_W_L) ? ROW_W_L : pattern_length;

  always_comb begin
    for (int i = 0; i < ROW_W; i++) begin
      len_mask[i] = (i < int'(len_used));
      match[i]    = (pattern_symbols[2*i +: SYM_W] == item.symbol);
    end
  end

  // V holds a one where the row does not rise. The sum carries a run of
  // non-rising positions up to the next match, which is where the row
  // gains a step.
  assign row      = item.first ? '0 : dp_row;
  assign v_old    = ~row & len_mask;
  assign u        = v_old & match;
  assign v_new    = (v_old + u) | (v_old & ~match);
  assign mask_new = ~v_new & len_mask;

  assign row_mask   = ROW_BITS'(mask_new);
  assign lcs_length = popcount_row(ROW_BITS'(mask_new));

endmodule

### sv/lcs_row_update_stream.sv
// Top level of the LCS row update stream: handshakes, registers and row state.
//
//   Channel   Direction  Handshake          Contents
//   s_*       in         tvalid / tready    tdata: symbol; tuser: first
//   m_*       out        tvalid / tready    tdata: row_mask, lcs_length
//   cfg_*     in         valid / ready      cfg_index, cfg_data
//
// One symbol is taken per cycle while the result side does not stall; each
// request passes through the input register and then the result register.
// The row is updated by a single add-and-mask pass over the pattern width,
// so a symbol may follow its predecessor in the very next cycle.
// Reset is synchronous and clears both registers' valid flags, the stored
// row and the configuration (pattern zero, length fifteen).
// A stall on the result side holds the result register; the input register
// still takes one more request, after which s_tready drops.
// Configuration is always ready and must only be written while idle.
module lcs_row_update_stream #(
  parameter int MAX_PATTERN = lcsru_pkg::MAX_PATTERN_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Text symbols.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [lcsru_pkg::S_TDATA_W-1:0]     s_tdata,  // [1:0] symbol
  input  logic                                s_tuser,  // [0] first
  // Row results.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [lcsru_pkg::M_TDATA_W-1:0]     m_tdata,  // [14:0] row_mask, [18:15] lcs_length
  // Configuration writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lcsru_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lcsru_pkg::PAT_W-1:0]         cfg_data
);
  import lcsru_pkg::*;

  `include "lcs_row_update_stream_assert.svh"

  // Only as many row bits are stored as the pattern can ever use.
  localparam int ROW_W = (MAX_PATTERN < ROW_BITS) ? MAX_PATTERN : ROW_BITS;

  logic [PAT_W-1:0]    pattern_symbols;
  logic [LEN_W-1:0]    pattern_length;

  logic                in_valid;
  item_t               in_item;
  logic                out_valid;
  logic [ROW_BITS-1:0] out_mask;
  logic [LEN_W-1:0]    out_len;
  logic [ROW_W-1:0]    dp_row;

  logic                advance;
  logic [ROW_BITS-1:0] row_mask;
  logic [LEN_W-1:0]    lcs_length;

  // The input register moves on whenever the result register is empty or
  // being drained in the same cycle.
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  assign m_tvalid = out_valid;
  assign m_tdata  = {(M_TDATA_W - ROW_BITS - LEN_W)'(0), out_len, out_mask};

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_symbols <= '0;
      pattern_length  <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PATTERN: pattern_symbols <= cfg_data;
        CFG_LENGTH:  pattern_length  <= cfg_data[LEN_W-1:0];
        default:     pattern_symbols <= pattern_symbols;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.symbol <= s_tdata[SYM_W-1:0];
      in_item.first  <= s_tuser;
    end
  end

  lcsru_core #(
    .ROW_W (ROW_W)
  ) u_core (
    .item            (in_item),
    .dp_row          (dp_row),
    .pattern_symbols (pattern_symbols),
    .pattern_length  (pattern_length),
    .row_mask        (row_mask),
    .lcs_length      (lcs_length)
  );

  // Result register and stored row; both load when a request leaves the
  // input register, so the next symbol sees the updated row.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      dp_row    <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        dp_row    <= row_mask[ROW_W-1:0];
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_mask <= row_mask;
      out_len  <= lcs_length;
    end
  end

  `LCSRU_ASSERT_NEXT(a_accept_fills_input, s_tvalid && s_tready, in_valid)
  `LCSRU_ASSERT_NEXT(a_advance_fills_output, advance, out_valid && dp_row == out_mask[ROW_W-1:0])
  `LCSRU_ASSERT_NOW(a_length_is_popcount, out_valid, out_len == LEN_W'($countones(out_mask)))
  `LCSRU_ASSERT_NOW(a_length_bounded, out_valid, out_len <= pattern_length)
  `LCSRU_ASSERT_NOW(a_mask_within_length, out_valid, (out_mask >> pattern_length) == '0)

endmodule
